// ----- hw/rtl/fqd_pkg.sv -----
// ---------------------------------------------------------------------------
// fqd_pkg
// shared codes and controller/datapath interface types for the queue
// ---------------------------------------------------------------------------
package fqd_pkg;

  localparam int ValueWidth = 32;

  localparam logic [1:0] ACT_ENQ = 2'd0;
  localparam logic [1:0] ACT_DEQ = 2'd1;
  localparam logic [1:0] ACT_DEL = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_VAL  = 2'd1;
  localparam logic [1:0] SEL_RD   = 2'd2;

  typedef struct packed {
    logic       load;
    logic       enq;
    logic       rd_head;
    logic       pop;
    logic       scan_start;
    logic       scan_step;
    logic       shift_start;
    logic       shift_step;
    logic       remove;
    logic       res_load;
    logic [1:0] res_status;
    logic [1:0] res_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       empty;
    logic       full;
    logic       match;
    logic       sweep_end;
    logic       res_free;
  } stat_t;

endpackage

// ----- hw/rtl/fqd_datapath.sv -----
// ---------------------------------------------------------------------------
// fqd_datapath
// circular entry memory, head pointer, count, sweep pointer and result register
// ---------------------------------------------------------------------------
module fqd_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [39:0]   s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [39:0]   m_tdata,
  input  fqd_pkg::cmd_t cmd,
  output fqd_pkg::stat_t stat
);
  import fqd_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = AW + 1;

  logic [ValueWidth-1:0] mem [QUEUE_DEPTH];
  logic [ValueWidth-1:0] rd_data;
  logic [ValueWidth-1:0] val_r;
  logic [1:0]            act_r;
  logic [AW-1:0]         head;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic                  pend;

  logic [1:0]            res_status;
  logic [ValueWidth-1:0] res_data;
  logic [4:0]            res_occ;

  logic                  sweep;
  logic                  sweep_rd;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ValueWidth-1:0] wr_data;

  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign sweep    = cmd.scan_step | cmd.shift_step;
  assign sweep_rd = sweep && (idx < count);
  assign rd_en    = cmd.rd_head | sweep_rd;
  assign rd_addr  = cmd.rd_head ? head : wrap_addr(head, idx);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wrap_addr(head, count);
    wr_data = val_r;
    if (cmd.enq) begin
      wr_en = 1'b1;
    end else if (cmd.shift_step && pend) begin
      wr_en   = 1'b1;
      wr_addr = wrap_addr(head, idx - CW'(2));
      wr_data = rd_data;
    end
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= s_tdata[1:0];
      val_r <= s_tdata[33:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      idx   <= '0;
      pend  <= 1'b0;
    end else begin
      if (cmd.enq) begin
        count <= count + CW'(1);
      end
      if (cmd.pop) begin
        head  <= wrap_addr(head, CW'(1));
        count <= count - CW'(1);
      end
      if (cmd.remove) begin
        count <= count - CW'(1);
      end
      if (cmd.scan_start) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (cmd.shift_start) begin
        pend <= 1'b0;
      end else if (sweep) begin
        pend <= sweep_rd;
        if (sweep_rd) begin
          idx <= idx + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_occ    <= 5'(count);
      case (cmd.res_sel)
        SEL_VAL: res_data <= val_r;
        SEL_RD:  res_data <= rd_data;
        default: res_data <= '0;
      endcase
    end
  end

  assign m_tdata = {1'b0, res_occ, res_data, res_status};

  assign stat.act       = act_r;
  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CW'(QUEUE_DEPTH));
  assign stat.match     = pend && (rd_data == val_r);
  assign stat.sweep_end = (idx == count) && !pend;
  assign stat.res_free  = !m_tvalid || m_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_enq_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.enq |-> !stat.full)
    else $error("write into full queue");

  a_take_not_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop || cmd.remove) |-> !stat.empty)
    else $error("entry taken from empty queue");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> m_tvalid)
    else $error("loaded result not presented");

endmodule

// ----- hw/rtl/fqd_ctrl.sv -----
// ---------------------------------------------------------------------------
// fqd_ctrl
// command sequencer: decode, search sweep, gap-closing shift and result hand-off
// ---------------------------------------------------------------------------
module fqd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  fqd_pkg::stat_t stat,
  output fqd_pkg::cmd_t  cmd
);
  import fqd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_DEQ    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] res_status;
  logic [1:0] res_status_next;
  logic [1:0] res_sel;
  logic [1:0] res_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
      res_sel    <= SEL_ZERO;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_sel    <= res_sel_next;
    end
  end

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_sel_next    = res_sel;
    cmd             = '0;
    cmd.res_status  = res_status;
    cmd.res_sel     = res_sel;
    s_tready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next      = S_FINISH;
        res_status_next = ST_OK;
        res_sel_next    = SEL_ZERO;
        case (stat.act)
          ACT_ENQ: begin
            if (stat.full) begin
              res_status_next = ST_FULL;
            end else begin
              cmd.enq      = 1'b1;
              res_sel_next = SEL_VAL;
            end
          end
          ACT_DEQ: begin
            if (stat.empty) begin
              res_status_next = ST_EMPTY;
            end else begin
              cmd.rd_head = 1'b1;
              state_next  = S_DEQ;
            end
          end
          ACT_DEL: begin
            if (stat.empty) begin
              res_status_next = ST_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            res_status_next = ST_OK;
          end
        endcase
      end
      S_DEQ: begin
        cmd.pop         = 1'b1;
        res_status_next = ST_OK;
        res_sel_next    = SEL_RD;
        state_next      = S_FINISH;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.shift_start = 1'b1;
          res_status_next = ST_OK;
          res_sel_next    = SEL_VAL;
          state_next      = S_SHIFT;
        end else if (stat.sweep_end) begin
          res_status_next = ST_NOT_FOUND;
          res_sel_next    = SEL_ZERO;
          state_next      = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.sweep_end) begin
          cmd.remove = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.res_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted transaction not decoded");

  a_one_sweep: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.scan_step, cmd.shift_step, cmd.rd_head, cmd.enq}) <= 1)
    else $error("conflicting memory commands");

  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> stat.res_free)
    else $error("result overwritten before taken");

endmodule

// ----- hw/rtl/fifo_queue_with_delete_by_value.sv -----
// ---------------------------------------------------------------------------
// fifo_queue_with_delete_by_value
// bounded fifo of 32-bit values with enqueue, dequeue and delete-first-match
// ---------------------------------------------------------------------------
// Entries live in a single-port-read, single-port-write circular memory of
// QUEUE_DEPTH words. One command enters per transaction and returns one result
// (status, value, occupancy after the command). A delete sweeps the memory from
// the head one entry per cycle, then shifts the entries behind the match one per
// cycle to close the gap. A new command is accepted while the previous result
// still waits on the master side.
module fifo_queue_with_delete_by_value #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action[1:0], value[33:2], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], data_out[33:2], occupancy[38:34], pad
);
  import fqd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fqd_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ----- bench/fqd_queue_checker.sv -----
// ---------------------------------------------------------------------------
// fqd_queue_checker
// watches both stream channels, keeps a shadow copy of the queue and checks
// every result (status, value, occupancy) in order against its prediction
// ---------------------------------------------------------------------------
module fqd_queue_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // action[1:0], value[33:2], zero pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // status[1:0], data_out[33:2], occupancy[38:34], pad
  output int          errors,
  output int          pending,
  output int          checked,
  output int          full_refusals,
  output int          misses,
  output int          empty_hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import fqd_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [4:0]  occupancy;
  } queue_result_t;

  logic [31:0]   entries [QUEUE_DEPTH];
  int            held = 0;
  queue_result_t expected_results [$];
  int            n_err = 0;
  int            n_chk = 0;
  int            n_full = 0;
  int            n_miss = 0;
  int            n_empty = 0;

  function automatic void close_gap(input int pos);
    for (int i = pos; i < held - 1; i++) entries[i] = entries[i + 1];
    held--;
  endfunction

  function automatic queue_result_t queue_apply(input logic [1:0] act, input logic [31:0] val);
    queue_result_t r;
    r.status = ST_OK;
    r.data = '0;
    case (act)
      ACT_ENQ: begin
        if (held >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          entries[held] = val;
          held++;
          r.data = val;
        end
      end
      ACT_DEQ: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = entries[0];
          close_gap(0);
        end
      end
      ACT_DEL: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < held; i++) begin
            if (entries[i] == val) begin
              r.status = ST_OK;
              r.data = val;
              close_gap(i);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.occupancy = 5'(held);
    return r;
  endfunction

  function automatic void report(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    n_err++;
    if (n_err <= 100)
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
  endfunction

  always @(posedge clk) begin : watch
    queue_result_t want;
    queue_result_t got;
    if (rst) begin
      held = 0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[1:0], m_tdata[33:2], m_tdata[38:34]};
        n_chk++;
        if (expected_results.size() == 0) begin
          n_err++;
          if (n_err <= 100)
            $display("%0t ns: unexpected result, expected none actual %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) report("status", 32'(want.status), 32'(got.status));
          if (got.data !== want.data) report("data_out", want.data, got.data);
          if (got.occupancy !== want.occupancy)
            report("occupancy", 32'(want.occupancy), 32'(got.occupancy));
        end
      end
      if (s_tvalid && s_tready) begin
        want = queue_apply(s_tdata[1:0], s_tdata[33:2]);
        case (want.status)
          ST_FULL:      n_full++;
          ST_NOT_FOUND: n_miss++;
          ST_EMPTY:     n_empty++;
          default: ;
        endcase
        expected_results.push_back(want);
      end
    end
    errors <= n_err;
    pending <= expected_results.size();
    checked <= n_chk;
    full_refusals <= n_full;
    misses <= n_miss;
    empty_hits <= n_empty;
  end

endmodule

// ----- bench/tb_fifo_queue_with_delete_by_value.sv -----
// ---------------------------------------------------------------------------
// tb_fifo_queue_with_delete_by_value
// drives enqueue, dequeue, delete and idle commands into the queue with
// random gaps and stalls on both streams; the checker predicts every result
// ---------------------------------------------------------------------------
module tb_fifo_queue_with_delete_by_value;
  timeunit 1ns;
  timeprecision 1ps;
  import fqd_pkg::*;

  localparam int         Depth      = 16;
  localparam int         Items      = 900;
  localparam int         HoldCycles = 400;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int errors;
  int pending;
  int checked;
  int full_refusals;
  int misses;
  int empty_hits;

  int          sent = 0;
  bit          burst = 1'b0;
  bit          rx_hold_req = 1'b0;
  logic [31:0] pool [8];

  fifo_queue_with_delete_by_value #(
    .QUEUE_DEPTH(Depth)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  fqd_queue_checker #(
    .QUEUE_DEPTH(Depth)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .errors(errors),
    .pending(pending),
    .checked(checked),
    .full_refusals(full_refusals),
    .misses(misses),
    .empty_hits(empty_hits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd10_000_000);
    $display("simulation failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_cmd(input logic [1:0] act, input logic [31:0] val);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, val, act};
    do @(posedge clk); while (!s_tready);
    sent++;
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_side
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid && !rx_hold_req);
      gap = burst ? 0 : idle_len();
      if (gap > 0 && !rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : command_side
    logic [31:0] fill_vals [16];
    int          mode;
    int          r;
    logic [1:0]  act;
    logic [31:0] val;

    fill_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                  32'h0000_0001, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'h0000_0001,
                  32'h8000_0000, 32'h1234_5678, 32'hffff_fffe, 32'h0000_0002,
                  32'h0000_ffff, 32'hffff_0000, 32'h3c3c_c3c3, 32'h7fff_fffe};
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue corner cases
    send_cmd(ACT_DEQ, 32'h0000_0000);
    send_cmd(ACT_DEL, 32'h0000_0005);
    send_cmd(ACT_NOP, 32'hffff_ffff);
    // fill to the top with extremes and duplicates, then overflow
    for (int i = 0; i < 16; i++) send_cmd(ACT_ENQ, fill_vals[i]);
    send_cmd(ACT_ENQ, 32'h3333_3333);
    // delete absent, first of duplicates, tail, head
    send_cmd(ACT_DEL, 32'h4444_4444);
    send_cmd(ACT_DEL, 32'h0000_0001);
    send_cmd(ACT_DEL, 32'h7fff_fffe);
    send_cmd(ACT_DEL, 32'h8000_0000);

    mode = 0;
    for (int n = 0; n < Items; n++) begin
      if (n % 30 == 0) begin
        mode = $urandom_range(0, 2);
        burst = ($urandom_range(0, 4) == 0);
        if (n == 300) begin
          burst = 1'b1;
          rx_hold_req = 1'b1;
        end
      end
      if (n == 600) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      r = $urandom_range(0, 99);
      case (mode)
        0:       act = (r < 60) ? ACT_ENQ : (r < 75) ? ACT_DEQ : (r < 95) ? ACT_DEL : ACT_NOP;
        1:       act = (r < 30) ? ACT_ENQ : (r < 70) ? ACT_DEQ : (r < 95) ? ACT_DEL : ACT_NOP;
        default: act = (r < 45) ? ACT_ENQ : (r < 65) ? ACT_DEQ : (r < 97) ? ACT_DEL : ACT_NOP;
      endcase
      val = $urandom;
      if (act == ACT_ENQ && $urandom_range(0, 99) < 60) val = pool[$urandom_range(0, 7)];
      if (act == ACT_DEL && $urandom_range(0, 99) < 75) val = pool[$urandom_range(0, 7)];
      send_cmd(act, val);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("ran %0d commands (enqueue, dequeue, delete by value, idle code) with stalls",
             sent);
    $display("checked %0d results: %0d refused when full, %0d on empty, %0d not found",
             checked, full_refusals, empty_hits, misses);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/fqd_pkg.sv
hw/rtl/fqd_datapath.sv
hw/rtl/fqd_ctrl.sv
hw/rtl/fifo_queue_with_delete_by_value.sv
bench/fqd_queue_checker.sv
bench/tb_fifo_queue_with_delete_by_value.sv
